// ===== src/mesh_face_area_mean_defines.svh =====
// Assertion macros shared by the mesh face area RTL.
// Used by the top level; no other dependencies.
`ifndef MESH_FACE_AREA_MEAN_DEFINES_SVH
`define MESH_FACE_AREA_MEAN_DEFINES_SVH

// Checked outside reset only.
`define MFAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MFAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/mfam_pkg.sv =====
// Package for the mesh face area block: widths, codes and the vertex type.
// No dependencies; used by the interfaces, the square root unit and the top level.
package mfam_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int MAX_FACES_DEF    = 65536;

  localparam int SLOT_W   = 12;
  localparam int CORNER_W = 13;
  localparam int COORD_W  = 24;
  localparam int VTX_W    = 3 * COORD_W;
  localparam int AREA_W   = 48;
  localparam int TOTAL_W  = 56;
  localparam int COUNT_W  = 17;
  localparam int COUNT_MAX = 131071;

  localparam int EDGE_W   = COORD_W + 1;
  localparam int CROSS_W  = 51;
  localparam int SPLIT    = 26;
  localparam int MUL_W    = 27;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 104;
  localparam int SUMSQ_W  = 102;
  localparam int ROOT_W   = SUMSQ_W / 2;
  localparam int AREA_SHIFT = 17;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_FACE   = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

endpackage

// ===== src/mfam_ifs.sv =====
// Valid/ready channel interfaces for the mesh face area block.
// Depends on mfam_pkg for the field widths.
interface mfam_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic [mfam_pkg::SLOT_W-1:0]          vertex_slot;
  logic signed [mfam_pkg::COORD_W-1:0]  pos_x;
  logic signed [mfam_pkg::COORD_W-1:0]  pos_y;
  logic signed [mfam_pkg::COORD_W-1:0]  pos_z;
  logic [mfam_pkg::CORNER_W-1:0]        corner_a;
  logic [mfam_pkg::CORNER_W-1:0]        corner_b;
  logic [mfam_pkg::CORNER_W-1:0]        corner_c;
  logic [mfam_pkg::CORNER_W-1:0]        corner_d;
  logic                                 final_face;

  modport source (output valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, corner_d, final_face,
                  input ready);
  modport sink (input valid, req_type, vertex_slot, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, corner_d, final_face,
                output ready);
endinterface

interface mfam_result_if;
  logic                          valid;
  logic                          ready;
  logic [mfam_pkg::AREA_W-1:0]   area_out;
  logic [mfam_pkg::AREA_W-1:0]   mean_out;
  logic                          mean_valid;
  logic                          no_area_flag;

  modport source (output valid, area_out, mean_out, mean_valid, no_area_flag,
                  input ready);
  modport sink (input valid, area_out, mean_out, mean_valid, no_area_flag,
                output ready);
endinterface

// ===== src/mesh_face_area_mean.sv =====
// Mesh face area and mean. Vertex beats write the vertex store. A face beat
// reads its present corners from the store one per cycle, then per triangle
// uses the shared 27x27 multiplier to form the cross product and its square,
// and then the bit-serial square root, which dominates. A face with fewer than
// three corners skips straight to the accumulate step, a face with four corners
// takes two triangles, and a final face adds the bit-serial divider that forms
// the mean. Vertex beats are taken while a face result waits at the output
// register.
// Depends on mfam_pkg, mfam_ifs, mfam_ram, mfam_isqrt and the defines header.
`include "mesh_face_area_mean_defines.svh"

module mesh_face_area_mean #(
  parameter int VERTEX_DEPTH = mfam_pkg::VERTEX_DEPTH_DEF,
  parameter int MAX_FACES    = mfam_pkg::MAX_FACES_DEF
) (
  input logic           clk,
  input logic           rst,
  mfam_item_if.sink     item,
  mfam_result_if.source result
);

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam int XW = (AW > mfam_pkg::CORNER_W) ? AW : mfam_pkg::CORNER_W;
  localparam logic [mfam_pkg::COUNT_W-1:0] COUNT_CAP =
    mfam_pkg::COUNT_W'((MAX_FACES < mfam_pkg::COUNT_MAX) ? MAX_FACES : mfam_pkg::COUNT_MAX);
  localparam int TW = mfam_pkg::TOTAL_W;
  localparam int CW = mfam_pkg::COUNT_W;
  localparam int DCNT_W = $clog2(TW);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_EDGE  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_SWAIT = 4'd6;
  localparam logic [3:0] S_ACCUM = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic [3:0] STEP_LAST = 4'd14;

  logic [3:0] state;

  logic [AW-1:0]   caddr [4];
  logic [2:0]      ncorn;
  logic            fin;
  logic [1:0]      rcnt;
  logic            rd_pend;
  logic [1:0]      rd_idx;
  mfam_pkg::vertex_t vtx [4];
  logic            tsel;

  logic signed [mfam_pkg::EDGE_W-1:0] ux, uy, uz, wx, wy, wz;
  logic [3:0]      step;
  logic            mvld;
  logic [3:0]      md;
  logic signed [mfam_pkg::MUL_W-1:0]  opa, opb;
  logic signed [mfam_pkg::PROD_W-1:0] prod, tmp, pdiff;
  logic signed [mfam_pkg::CROSS_W-1:0] x0, x1, x2;
  logic signed [mfam_pkg::ACC_W-1:0]  acc, pext;

  logic                          sq_start, sq_done;
  logic [mfam_pkg::ROOT_W-1:0]   sq_root;
  logic [mfam_pkg::AREA_W-1:0]   area;
  logic [mfam_pkg::AREA_W:0]     area_sum;

  logic [TW-1:0]   total;
  logic [CW-1:0]   count;
  logic [TW:0]     total_sum;
  logic [TW-1:0]   total_next;
  logic [CW-1:0]   count_next;

  logic [TW-1:0]   dq;
  logic [CW-1:0]   drem;
  logic [CW-1:0]   divisor;
  logic [DCNT_W-1:0] dcnt;
  logic [CW:0]     drv;
  logic            dge;
  logic            none;

  logic            ovld;
  logic [mfam_pkg::AREA_W-1:0] oarea, omean;
  logic            omv, onone;

  logic            accept, ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [mfam_pkg::VTX_W-1:0] ram_rdata;
  logic [XW-1:0]   slot_ext;
  logic [XW-1:0]   cext [4];
  logic [3:0]      pres;
  logic [AW-1:0]   clist [4];
  logic [2:0]      cnum;
  mfam_pkg::vertex_t p0, p1, p2;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  always_comb begin
    slot_ext  = XW'(item.vertex_slot);
    ram_we    = accept && (item.req_type == mfam_pkg::REQ_VERTEX) &&
                ({1'b0, slot_ext} < (XW + 1)'(VERTEX_DEPTH));
    ram_waddr = slot_ext[AW-1:0];
    ram_re    = (state == S_READ);
    ram_raddr = caddr[rcnt];
  end

  always_comb begin
    cext[0] = XW'(item.corner_a);
    cext[1] = XW'(item.corner_b);
    cext[2] = XW'(item.corner_c);
    cext[3] = XW'(item.corner_d);
    cnum = '0;
    for (int k = 0; k < 4; k++) begin
      clist[k] = '0;
    end
    for (int k = 0; k < 4; k++) begin
      pres[k] = {1'b0, cext[k]} < (XW + 1)'(VERTEX_DEPTH);
      if (pres[k]) begin
        clist[cnum[1:0]] = cext[k][AW-1:0];
        cnum = cnum + 3'd1;
      end
    end
  end

  mfam_ram #(
    .WIDTH (mfam_pkg::VTX_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({item.pos_x, item.pos_y, item.pos_z}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    p0 = vtx[0];
    p1 = tsel ? vtx[2] : vtx[1];
    p2 = tsel ? vtx[3] : vtx[2];
  end

  always_comb begin
    case (step)
      4'd0:  begin opa = mfam_pkg::MUL_W'(uy); opb = mfam_pkg::MUL_W'(wz); end
      4'd1:  begin opa = mfam_pkg::MUL_W'(uz); opb = mfam_pkg::MUL_W'(wy); end
      4'd2:  begin opa = mfam_pkg::MUL_W'(uz); opb = mfam_pkg::MUL_W'(wx); end
      4'd3:  begin opa = mfam_pkg::MUL_W'(ux); opb = mfam_pkg::MUL_W'(wz); end
      4'd4:  begin opa = mfam_pkg::MUL_W'(ux); opb = mfam_pkg::MUL_W'(wy); end
      4'd5:  begin opa = mfam_pkg::MUL_W'(uy); opb = mfam_pkg::MUL_W'(wx); end
      4'd6:  begin
        opa = mfam_pkg::MUL_W'($signed(x0[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = opa;
      end
      4'd7:  begin
        opa = mfam_pkg::MUL_W'(x0[mfam_pkg::SPLIT-1:0]);
        opb = opa;
      end
      4'd8:  begin
        opa = mfam_pkg::MUL_W'($signed(x0[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = mfam_pkg::MUL_W'(x0[mfam_pkg::SPLIT-1:0]);
      end
      4'd9:  begin
        opa = mfam_pkg::MUL_W'($signed(x1[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = opa;
      end
      4'd10: begin
        opa = mfam_pkg::MUL_W'(x1[mfam_pkg::SPLIT-1:0]);
        opb = opa;
      end
      4'd11: begin
        opa = mfam_pkg::MUL_W'($signed(x1[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = mfam_pkg::MUL_W'(x1[mfam_pkg::SPLIT-1:0]);
      end
      4'd12: begin
        opa = mfam_pkg::MUL_W'($signed(x2[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = opa;
      end
      4'd13: begin
        opa = mfam_pkg::MUL_W'(x2[mfam_pkg::SPLIT-1:0]);
        opb = opa;
      end
      4'd14: begin
        opa = mfam_pkg::MUL_W'($signed(x2[mfam_pkg::CROSS_W-1:mfam_pkg::SPLIT]));
        opb = mfam_pkg::MUL_W'(x2[mfam_pkg::SPLIT-1:0]);
      end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_comb begin
    pdiff = tmp - prod;
    pext  = mfam_pkg::ACC_W'(prod);
    case (md)
      4'd6, 4'd9, 4'd12:  pext = pext <<< (2 * mfam_pkg::SPLIT);
      4'd8, 4'd11, 4'd14: pext = pext <<< (mfam_pkg::SPLIT + 1);
      default:            pext = pext;
    endcase
  end

  mfam_isqrt u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (acc[mfam_pkg::SUMSQ_W-1:0]),
    .done    (sq_done),
    .root    (sq_root)
  );

  assign sq_start = (state == S_SQRT);

  always_comb begin
    area_sum   = {1'b0, area} +
                 (mfam_pkg::AREA_W + 1)'(sq_root[mfam_pkg::ROOT_W-1:mfam_pkg::AREA_SHIFT]);
    total_sum  = {1'b0, total} + (TW + 1)'(area);
    total_next = total_sum[TW] ? '1 : total_sum[TW-1:0];
    count_next = ((area != '0) && (count < COUNT_CAP)) ? count + 1'b1 : count;
    drv        = {drem, dq[TW-1]};
    dge        = drv >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      mvld    <= 1'b0;
      total   <= '0;
      count   <= '0;
      ovld    <= 1'b0;
    end else begin
      rd_pend <= (state == S_READ);
      mvld    <= (state == S_MUL) && (step <= STEP_LAST);
      if ((state == S_DONE) && (!ovld || result.ready)) begin
        ovld <= 1'b1;
      end else if (result.ready) begin
        ovld <= 1'b0;
      end
      if (rd_pend) begin
        vtx[rd_idx] <= ram_rdata;
      end
      case (state)
        S_IDLE: begin
          if (accept && (item.req_type == mfam_pkg::REQ_FACE)) begin
            caddr <= clist;
            ncorn <= cnum;
            fin   <= item.final_face;
            rcnt  <= '0;
            area  <= '0;
            tsel  <= 1'b0;
            state <= (cnum < 3'd3) ? S_ACCUM : S_READ;
          end
        end
        S_READ: begin
          rd_idx  <= rcnt;
          rcnt    <= rcnt + 1'b1;
          if ({1'b0, rcnt} == ncorn - 3'd1) begin
            state <= S_RWAIT;
          end
        end
        S_RWAIT: begin
          state <= S_EDGE;
        end
        S_EDGE: begin
          ux    <= mfam_pkg::EDGE_W'(p1.x) - mfam_pkg::EDGE_W'(p0.x);
          uy    <= mfam_pkg::EDGE_W'(p1.y) - mfam_pkg::EDGE_W'(p0.y);
          uz    <= mfam_pkg::EDGE_W'(p1.z) - mfam_pkg::EDGE_W'(p0.z);
          wx    <= mfam_pkg::EDGE_W'(p2.x) - mfam_pkg::EDGE_W'(p0.x);
          wy    <= mfam_pkg::EDGE_W'(p2.y) - mfam_pkg::EDGE_W'(p0.y);
          wz    <= mfam_pkg::EDGE_W'(p2.z) - mfam_pkg::EDGE_W'(p0.z);
          step  <= '0;
          acc   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (step <= STEP_LAST) begin
            prod <= opa * opb;
            md   <= step;
            step <= step + 1'b1;
          end
          if (mvld) begin
            case (md)
              4'd0, 4'd2, 4'd4: tmp <= prod;
              4'd1: x0 <= pdiff[mfam_pkg::CROSS_W-1:0];
              4'd3: x1 <= pdiff[mfam_pkg::CROSS_W-1:0];
              4'd5: x2 <= pdiff[mfam_pkg::CROSS_W-1:0];
              default: acc <= acc + pext;
            endcase
            if (md == STEP_LAST) begin
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          state <= S_SWAIT;
        end
        S_SWAIT: begin
          if (sq_done) begin
            area <= area_sum[mfam_pkg::AREA_W] ? '1 : area_sum[mfam_pkg::AREA_W-1:0];
            if (!tsel && (ncorn == 3'd4)) begin
              tsel  <= 1'b1;
              state <= S_EDGE;
            end else begin
              state <= S_ACCUM;
            end
          end
        end
        S_ACCUM: begin
          if (fin) begin
            total   <= '0;
            count   <= '0;
            dq      <= (count_next == '0) ? '0 : total_next;
            divisor <= count_next;
            drem    <= '0;
            dcnt    <= '0;
            none    <= (count_next == '0);
            state   <= (count_next == '0) ? S_DONE : S_DIV;
          end else begin
            dq    <= '0;
            none  <= 1'b0;
            total <= total_next;
            count <= count_next;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          drem <= dge ? CW'(drv - {1'b0, divisor}) : CW'(drv);
          dq   <= {dq[TW-2:0], dge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(TW - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ovld || result.ready) begin
            oarea <= area;
            omean <= (dq[TW-1:mfam_pkg::AREA_W] != '0) ? '1 : dq[mfam_pkg::AREA_W-1:0];
            omv   <= fin;
            onone <= none;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid        = ovld;
  assign result.area_out     = oarea;
  assign result.mean_out     = omean;
  assign result.mean_valid   = omv;
  assign result.no_area_flag = onone;

  `MFAM_ASSERT(a_none_means_zero, result.valid && result.no_area_flag |-> result.mean_valid && (result.mean_out == '0), "empty mean must be flagged final and zero")
  `MFAM_ASSERT(a_plain_face, result.valid && !result.mean_valid |-> (result.mean_out == '0) && !result.no_area_flag, "non-final face carries a mean")
  `MFAM_ASSERT_ALWAYS(a_count_cap, rst || (count <= COUNT_CAP), "face count above its cap")
  `MFAM_ASSERT(a_vertex_idle, accept && (item.req_type == mfam_pkg::REQ_VERTEX) |=> state == S_IDLE, "vertex beat left the idle state")

endmodule

// ===== src/mfam_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module mfam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mfam_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
// Depends on mfam_pkg for the operand and root widths.
module mfam_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mfam_pkg::SUMSQ_W-1:0]  operand,
  output logic                          done,
  output logic [mfam_pkg::ROOT_W-1:0]   root
);

  localparam int RW    = mfam_pkg::ROOT_W;
  localparam int REM_W = RW + 2;
  localparam int CNT_W = $clog2(RW);

  logic [mfam_pkg::SUMSQ_W-1:0] op;
  logic [REM_W-1:0]             rem;
  logic [CNT_W-1:0]             cnt;
  logic                         busy;
  logic [REM_W+1:0]             rv;
  logic [REM_W+1:0]             trial;
  logic                         ge;

  always_comb begin
    rv    = {rem, op[mfam_pkg::SUMSQ_W-1 -: 2]};
    trial = (REM_W + 2)'({root, 2'b01});
    ge    = rv >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(RW - 1));
      if (start) begin
        busy <= 1'b1;
        op   <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        op   <= {op[mfam_pkg::SUMSQ_W-3:0], 2'b00};
        rem  <= ge ? REM_W'(rv - trial) : REM_W'(rv);
        root <= {root[RW-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(RW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
